/* hw/rtl/sldf_pkg.sv */
package sldf_pkg;

  // Receive phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_SYNC1 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  // Error codes reported with each result
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LEN  = 2'd1,
    ERR_SUM  = 2'd2
  } err_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC0  = 2'd0;
  localparam logic [1:0] REG_SYNC1  = 2'd1;
  localparam logic [1:0] REG_MAXLEN = 2'd2;

  // Configuration reset values
  localparam logic [7:0] SYNC0_RST  = 8'd170;
  localparam logic [7:0] SYNC1_RST  = 8'd85;
  localparam logic [7:0] MAXLEN_RST = 8'd255;

  // One result transaction
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_complete;
    err_t       error_code;
  } result_t;

endpackage

/* hw/rtl/sldf_in_reg.sv */
module sldf_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       valid_r,
  output logic [7:0] byte_r
);
  import sldf_pkg::*;

  // Accept when empty or when the held byte moves on this cycle
  assign in_tready = !valid_r || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Hold the byte
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

/* hw/rtl/sldf_core.sv */
module sldf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [7:0]        cfg_data,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output sldf_pkg::result_t res
);
  import sldf_pkg::*;

  logic [7:0] sync0_r;
  logic [7:0] sync1_r;
  logic [7:0] max_len_r;

  phase_t     phase_r, phase_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_add;
  logic [8:0] rem_dec;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync0_r   <= SYNC0_RST;
      sync1_r   <= SYNC1_RST;
      max_len_r <= MAXLEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SYNC0:  sync0_r   <= cfg_data;
        REG_SYNC1:  sync1_r   <= cfg_data;
        REG_MAXLEN: max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_add = sum_r + rx_byte;
  assign rem_dec = (rem_r != 9'd0) ? rem_r - 9'd1 : rem_r;

  // Frame state update and result for one byte
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    res       = '0;
    res.error_code = ERR_NONE;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == sync0_r) phase_nxt = PH_SYNC1;
      end
      PH_SYNC1: begin
        phase_nxt = (rx_byte == sync1_r) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        if (rx_byte <= max_len_r) begin
          len_nxt   = rx_byte;
          rem_nxt   = {1'b0, rx_byte} + 9'd1;
          sum_nxt   = 8'd0;
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt      = PH_HUNT;
          res.error_code = ERR_LEN;
        end
      end
      PH_BODY: begin
        sum_nxt = sum_add;
        // Checksum byte comes first; payload follows it
        if (rem_r != 9'd0 && rem_r <= {1'b0, len_r}) begin
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = len_r - rem_r[7:0];
        end
        rem_nxt = rem_dec;
        if (rem_dec == 9'd0) begin
          if (sum_add == 8'd0) res.frame_complete = 1'b1;
          else                 res.error_code     = ERR_SUM;
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Advance frame state once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      rem_r   <= 9'd0;
      sum_r   <= 8'd0;
      len_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

/* hw/rtl/sldf_out_reg.sv */
module sldf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sldf_pkg::result_t res,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tlast,
  output logic [0:0]        out_tuser
);
  import sldf_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Hold a result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, res_r.error_code, res_r.payload_index, res_r.payload_byte};
  assign out_tlast  = res_r.frame_complete;
  assign out_tuser  = res_r.payload_valid;

endmodule

/* hw/rtl/sync_length_checksum_deframer.sv */
// Frame receiver for a byte stream laid out as sync0, sync1, length, checksum,
// then length payload bytes. Every accepted byte yields exactly one result
// transaction: payload bytes come out with their index (out_tuser high), the
// last byte of a frame whose 8-bit sum of checksum and payload is zero raises
// out_tlast, and a length above the limit or a nonzero sum is flagged in the
// error field; a consumer drops a frame's payload on error. The block takes
// one byte per clock while out_tready is high. A byte waits in the input
// register, and the frame state update (a compare and an 8-bit add) is
// combinational between that register and the result register, which holds
// the result until out_tready takes it. A stalled result holds the input
// register, which then drops in_tready. The user must write the sync values
// and the length limit through cfg_* only while no byte is held inside the
// block; the block itself does not enforce this. A write between the bytes
// of a frame applies to the next compare and keeps a length already accepted.
module sync_length_checksum_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [15:8] payload_index,
                                  // [17:16] error_code, [23:18] zero
  output logic        out_tlast,  // frame_complete
  output logic [0:0]  out_tuser   // [0] payload_valid
);
  import sldf_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       take;
  result_t    res;

  // Move a byte into the result register when that register frees up
  assign take = in_valid_r && (!out_tvalid || out_tready);

  sldf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .valid_r   (in_valid_r),
    .byte_r    (in_byte_r)
  );

  sldf_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .step     (take),
    .rx_byte  (in_byte_r),
    .res      (res)
  );

  sldf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  // A completed frame carries no error
  a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[17:16] == ERR_NONE)
    else $error("frame complete with error code");

  // A length error never comes with payload
  a_len_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] == ERR_LEN |-> !out_tuser[0])
    else $error("length error on a payload byte");

  // Error field holds a defined code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] == ERR_NONE || out_tdata[17:16] == ERR_LEN ||
                    out_tdata[17:16] == ERR_SUM))
    else $error("undefined error code");

  // Non-payload results carry zero byte and index
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[15:0] == 16'd0)
    else $error("payload fields set without payload");

  // A byte held in the input stage reaches the result register once it frees up
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_tvalid |=> out_tvalid)
    else $error("held byte did not advance");
`endif

endmodule
